### design/mtt_pkg.sv
// shared types, codes and helpers of the markup tag tokenizer
`timescale 1ns / 1ps

package mtt_pkg;

    localparam int MaxResults = 4;
    localparam int CountW     = $clog2(MaxResults + 1);

    // lexer modes
    localparam logic [1:0] MODE_TAG    = 2'd0;
    localparam logic [1:0] MODE_IDENT  = 2'd1;
    localparam logic [1:0] MODE_STRING = 2'd2;
    localparam logic [1:0] MODE_TEXT   = 2'd3;

    // token kinds
    localparam logic [2:0] K_OPEN    = 3'd0;
    localparam logic [2:0] K_CLOSE   = 3'd1;
    localparam logic [2:0] K_TAGEND  = 3'd2;
    localparam logic [2:0] K_SELFEND = 3'd3;
    localparam logic [2:0] K_EQUALS  = 3'd4;
    localparam logic [2:0] K_STRING  = 3'd5;
    localparam logic [2:0] K_IDENT   = 3'd6;
    localparam logic [2:0] K_TEXT    = 3'd7;

    // characters
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_NONE  = 8'h00;

    typedef struct packed {
        logic [1:0] mode;
        logic       pend_open;
        logic       pend_slash;
        logic       text_started;
        logic       pend_space;
    } t_lex_state;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch;
        logic       has;
        logic       st;
        logic       en;
    } t_result;

    function automatic t_result f_res(logic [2:0] kind, logic [7:0] ch, logic has,
                                      logic st, logic en);
        t_result r;
        r.kind = kind;
        r.ch   = has ? ch : CH_NONE;
        r.has  = has;
        r.st   = st;
        r.en   = en;
        return r;
    endfunction

endpackage

### design/mtt_lexer.sv
// per-byte lexer step: next state and the list of results for one item
`timescale 1ns / 1ps

module mtt_lexer (
    input  mtt_pkg::t_lex_state                            i_state,
    input  logic [7:0]                                     i_byte,
    input  logic                                           i_eoi,
    output mtt_pkg::t_lex_state                            o_state,
    output mtt_pkg::t_result [mtt_pkg::MaxResults-1:0]     o_res,
    output logic [mtt_pkg::CountW-1:0]                     o_cnt
);

    mtt_pkg::t_lex_state                        s;
    mtt_pkg::t_result [mtt_pkg::MaxResults-1:0] res;
    logic [mtt_pkg::CountW-1:0]                 cnt;
    logic                                       tag;
    logic                                       done;

    always_comb begin
        s    = i_state;
        res  = '0;
        cnt  = '0;
        tag  = 1'b0;
        done = 1'b0;

        unique case (s.mode)
            mtt_pkg::MODE_IDENT: begin
                if (i_byte == mtt_pkg::CH_SPACE || i_byte == mtt_pkg::CH_EQ ||
                    i_byte == mtt_pkg::CH_GT || i_byte == mtt_pkg::CH_NL) begin
                    res[cnt[1:0]] = mtt_pkg::f_res(mtt_pkg::K_IDENT, mtt_pkg::CH_NONE,
                                                   1'b0, 1'b0, 1'b1);
                    cnt    = cnt + 1'b1;
                    s.mode = mtt_pkg::MODE_TAG;
                    tag    = 1'b1;
                end else begin
                    res[cnt[1:0]] = mtt_pkg::f_res(mtt_pkg::K_IDENT, i_byte,
                                                   1'b1, 1'b0, 1'b0);
                    cnt = cnt + 1'b1;
                end
            end
            mtt_pkg::MODE_STRING: begin
                if (i_byte == mtt_pkg::CH_QUOTE) begin
                    res[cnt[1:0]] = mtt_pkg::f_res(mtt_pkg::K_STRING, mtt_pkg::CH_NONE,
                                                   1'b0, !s.text_started, 1'b1);
                    cnt            = cnt + 1'b1;
                    s.mode         = mtt_pkg::MODE_TAG;
                    s.text_started = 1'b0;
                end else begin
                    res[cnt[1:0]] = mtt_pkg::f_res(mtt_pkg::K_STRING, i_byte,
                                                   1'b1, !s.text_started, 1'b0);
                    cnt            = cnt + 1'b1;
                    s.text_started = 1'b1;
                end
            end
            mtt_pkg::MODE_TEXT: begin
                if (i_byte == mtt_pkg::CH_LT) begin
                    if (s.text_started) begin
                        res[cnt[1:0]] = mtt_pkg::f_res(mtt_pkg::K_TEXT, mtt_pkg::CH_NONE,
                                                       1'b0, 1'b0, 1'b1);
                        cnt = cnt + 1'b1;
                    end
                    s.mode         = mtt_pkg::MODE_TAG;
                    s.text_started = 1'b0;
                    s.pend_space   = 1'b0;
                    s.pend_open    = 1'b1;
                end else if (i_byte == mtt_pkg::CH_NL) begin
                    s.mode = mtt_pkg::MODE_TEXT;
                end else if (i_byte == mtt_pkg::CH_SPACE) begin
                    if (s.text_started) begin
                        s.pend_space = 1'b1;
                    end
                end else begin
                    // a held space is only shown once a non-space follows it
                    if (s.pend_space) begin
                        res[cnt[1:0]] = mtt_pkg::f_res(mtt_pkg::K_TEXT, mtt_pkg::CH_SPACE,
                                                       1'b1, 1'b0, 1'b0);
                        cnt = cnt + 1'b1;
                    end
                    res[cnt[1:0]] = mtt_pkg::f_res(mtt_pkg::K_TEXT, i_byte,
                                                   1'b1, !s.text_started, 1'b0);
                    cnt            = cnt + 1'b1;
                    s.text_started = 1'b1;
                    s.pend_space   = 1'b0;
                end
            end
            default: begin
                tag = 1'b1;
            end
        endcase

        if (tag) begin
            if (s.pend_open) begin
                s.pend_open = 1'b0;
                if (i_byte == mtt_pkg::CH_SLASH) begin
                    res[cnt[1:0]] = mtt_pkg::f_res(mtt_pkg::K_CLOSE, mtt_pkg::CH_LT,
                                                   1'b1, 1'b1, 1'b0);
                    cnt = cnt + 1'b1;
                    res[cnt[1:0]] = mtt_pkg::f_res(mtt_pkg::K_CLOSE, mtt_pkg::CH_SLASH,
                                                   1'b1, 1'b0, 1'b1);
                    cnt  = cnt + 1'b1;
                    done = 1'b1;
                end else begin
                    res[cnt[1:0]] = mtt_pkg::f_res(mtt_pkg::K_OPEN, mtt_pkg::CH_LT,
                                                   1'b1, 1'b1, 1'b1);
                    cnt = cnt + 1'b1;
                end
            end
            // a lone slash is dropped and the byte falls through to tag handling
            if (!done && s.pend_slash) begin
                s.pend_slash = 1'b0;
                if (i_byte == mtt_pkg::CH_GT) begin
                    res[cnt[1:0]] = mtt_pkg::f_res(mtt_pkg::K_SELFEND, mtt_pkg::CH_SLASH,
                                                   1'b1, 1'b1, 1'b0);
                    cnt = cnt + 1'b1;
                    res[cnt[1:0]] = mtt_pkg::f_res(mtt_pkg::K_SELFEND, mtt_pkg::CH_GT,
                                                   1'b1, 1'b0, 1'b1);
                    cnt  = cnt + 1'b1;
                    done = 1'b1;
                end
            end
            if (!done) begin
                unique case (i_byte)
                    mtt_pkg::CH_LT: begin
                        s.pend_open = 1'b1;
                    end
                    mtt_pkg::CH_GT: begin
                        res[cnt[1:0]] = mtt_pkg::f_res(mtt_pkg::K_TAGEND, mtt_pkg::CH_GT,
                                                       1'b1, 1'b1, 1'b1);
                        cnt            = cnt + 1'b1;
                        s.mode         = mtt_pkg::MODE_TEXT;
                        s.text_started = 1'b0;
                        s.pend_space   = 1'b0;
                    end
                    mtt_pkg::CH_SLASH: begin
                        s.pend_slash = 1'b1;
                    end
                    mtt_pkg::CH_EQ: begin
                        res[cnt[1:0]] = mtt_pkg::f_res(mtt_pkg::K_EQUALS, mtt_pkg::CH_EQ,
                                                       1'b1, 1'b1, 1'b1);
                        cnt = cnt + 1'b1;
                    end
                    mtt_pkg::CH_QUOTE: begin
                        s.mode         = mtt_pkg::MODE_STRING;
                        s.text_started = 1'b0;
                    end
                    mtt_pkg::CH_SPACE, mtt_pkg::CH_NL: begin
                        s.mode = mtt_pkg::MODE_TAG;
                    end
                    default: begin
                        res[cnt[1:0]] = mtt_pkg::f_res(mtt_pkg::K_IDENT, i_byte,
                                                       1'b1, 1'b1, 1'b0);
                        cnt    = cnt + 1'b1;
                        s.mode = mtt_pkg::MODE_IDENT;
                    end
                endcase
            end
        end

        if (i_eoi) begin
            if (s.pend_open) begin
                res[cnt[1:0]] = mtt_pkg::f_res(mtt_pkg::K_OPEN, mtt_pkg::CH_LT,
                                               1'b1, 1'b1, 1'b1);
                cnt = cnt + 1'b1;
            end
            unique case (s.mode)
                mtt_pkg::MODE_IDENT: begin
                    res[cnt[1:0]] = mtt_pkg::f_res(mtt_pkg::K_IDENT, mtt_pkg::CH_NONE,
                                                   1'b0, 1'b0, 1'b1);
                    cnt = cnt + 1'b1;
                end
                mtt_pkg::MODE_STRING: begin
                    // an unterminated string is closed here
                    res[cnt[1:0]] = mtt_pkg::f_res(mtt_pkg::K_STRING, mtt_pkg::CH_NONE,
                                                   1'b0, !s.text_started, 1'b1);
                    cnt = cnt + 1'b1;
                end
                mtt_pkg::MODE_TEXT: begin
                    if (s.text_started) begin
                        res[cnt[1:0]] = mtt_pkg::f_res(mtt_pkg::K_TEXT, mtt_pkg::CH_NONE,
                                                       1'b0, 1'b0, 1'b1);
                        cnt = cnt + 1'b1;
                    end
                end
                default: begin
                    s.mode = mtt_pkg::MODE_TAG;
                end
            endcase
            s = '0;
        end
    end

    assign o_state = s;
    assign o_res   = res;
    assign o_cnt   = cnt;

endmodule

### design/markup_tag_tokenizer.sv
// top level of the markup tag tokenizer: lexer state, result register and handshakes
`timescale 1ns / 1ps

// Byte-serial tokenizer for a small XML-like markup. Each accepted item (one source
// byte plus an end-of-input flag) is lexed in the cycle it is accepted and yields zero
// to four results, which land in a four-entry result register and leave one per cycle
// while i_stall is low, each tagged with its token kind, start and end marks, and a
// last-result flag on the final result of its item. An item that yields zero or one
// result stalls the input only while the output is stalled, so plain text and
// identifiers otherwise stream at one byte per clock; an item that yields more results
// stalls the input while the result register drains, and the next item is taken in
// the cycle the last pending result is taken.
// The lexer state returns to reset after an item flagged as end of input.
module markup_tag_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_token_kind,
    output logic [7:0] o_char_value,
    output logic       o_has_char,
    output logic       o_starts_token,
    output logic       o_ends_token,
    output logic       o_last_result
);

    mtt_pkg::t_lex_state                        r_state;
    mtt_pkg::t_lex_state                        n_state;
    mtt_pkg::t_result [mtt_pkg::MaxResults-1:0] r_buf;
    mtt_pkg::t_result [mtt_pkg::MaxResults-1:0] n_buf;
    logic [mtt_pkg::CountW-1:0]                 r_cnt;
    logic [mtt_pkg::CountW-1:0]                 n_cnt;
    logic                                       accept;
    logic                                       take;

    mtt_lexer u_lexer (
        .i_state (r_state),
        .i_byte  (i_in_byte),
        .i_eoi   (i_end_of_input),
        .o_state (n_state),
        .o_res   (n_buf),
        .o_cnt   (n_cnt)
    );

    assign o_valid = (r_cnt != '0);
    assign take    = o_valid && !i_stall;
    // room for a new item once the last pending result leaves
    assign o_stall = (r_cnt > mtt_pkg::CountW'(1)) || ((r_cnt == mtt_pkg::CountW'(1)) && i_stall);
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_cnt   <= '0;
        end else if (accept) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf <= n_buf;
        end else if (take) begin
            r_buf <= {{$bits(mtt_pkg::t_result){1'b0}}, r_buf[mtt_pkg::MaxResults-1:1]};
        end
    end

    assign o_token_kind   = r_buf[0].kind;
    assign o_char_value   = r_buf[0].ch;
    assign o_has_char     = r_buf[0].has;
    assign o_starts_token = r_buf[0].st;
    assign o_ends_token   = r_buf[0].en;
    assign o_last_result  = (r_cnt == mtt_pkg::CountW'(1));

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= mtt_pkg::CountW'(mtt_pkg::MaxResults))
        else $error("result count above buffer depth");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (r_cnt == '0) || ((r_cnt == mtt_pkg::CountW'(1)) && take))
        else $error("item accepted over pending results");

    a_flush_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_input) |=> (r_state == '0))
        else $error("state not cleared after end of input");

    a_pending_tag_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode != mtt_pkg::MODE_TAG) |-> (!r_state.pend_open && !r_state.pend_slash))
        else $error("pending lookahead outside tag mode");

endmodule
